@@ rtl/bhmp_pkg.sv @@
// ---------------------------------------------------------------------------
// bhmp_pkg
// Shared types and codes for the binary HTTP message parser core.
// ---------------------------------------------------------------------------
package bhmp_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IS_REQUEST   = 2'd0;
    localparam logic [1:0] CFG_END_CODE     = 2'd1;
    localparam logic [1:0] CFG_UNKNOWN_CODE = 2'd2;

    // Parse phases of the message.
    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_URL    = 4'd1,
        PH_STATUS = 4'd2,
        PH_HSTART = 4'd3,
        PH_KEY    = 4'd4,
        PH_VALUE  = 4'd5,
        PH_ESTART = 4'd6,
        PH_ENTITY = 4'd7,
        PH_DONE   = 4'd8
    } phase_t;

    // Parse events tagged on each byte.
    typedef enum logic [4:0] {
        EV_HELD        = 5'd0,
        EV_VERB        = 5'd1,
        EV_URL         = 5'd2,
        EV_URL_END     = 5'd3,
        EV_STATUS      = 5'd4,
        EV_KNOWN_KEY   = 5'd5,
        EV_UNKNOWN_KEY = 5'd6,
        EV_KEY_BYTE    = 5'd7,
        EV_KEY_END     = 5'd8,
        EV_VAL_BYTE    = 5'd9,
        EV_VAL_END     = 5'd10,
        EV_HDR_END     = 5'd11,
        EV_DONE        = 5'd12,
        EV_CHUNK_SIZE  = 5'd13,
        EV_ENTITY_END  = 5'd14,
        EV_ENTITY_BYTE = 5'd15,
        EV_UNCONSUMED  = 5'd16
    } event_t;

    // Configuration as seen by the parse logic.
    typedef struct packed {
        logic       is_request;
        logic [7:0] end_code;
        logic [7:0] unknown_code;
    } cfg_t;

    // One parse result.
    typedef struct packed {
        event_t      kind;
        logic [7:0]  byte_value;
        logic [15:0] word_value;
        logic        in_trailer;
        logic        last_of_chunk;
    } result_t;

endpackage

@@ rtl/bhmp_cfg.sv @@
// ---------------------------------------------------------------------------
// bhmp_cfg
// Configuration register file, written through a valid/ready channel.
// ---------------------------------------------------------------------------
module bhmp_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output bhmp_pkg::cfg_t cfg
);
    import bhmp_pkg::*;

    logic       is_request_reg;
    logic [7:0] end_code_reg;
    logic [7:0] unknown_code_reg;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Register file; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_request_reg   <= 1'b1;
            end_code_reg     <= 8'd0;
            unknown_code_reg <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_IS_REQUEST)
                is_request_reg <= cfg_data[0];
            else if (cfg_index == CFG_END_CODE)
                end_code_reg <= cfg_data;
            else if (cfg_index == CFG_UNKNOWN_CODE)
                unknown_code_reg <= cfg_data;
        end
    end

    assign cfg.is_request   = is_request_reg;
    assign cfg.end_code     = end_code_reg;
    assign cfg.unknown_code = unknown_code_reg;

endmodule

@@ rtl/bhmp_step.sv @@
// ---------------------------------------------------------------------------
// bhmp_step
// Parse state registers and the per-byte next-state and event logic.
// ---------------------------------------------------------------------------
module bhmp_step (
    input  logic               clk,
    input  logic               rst_n,
    input  bhmp_pkg::cfg_t     cfg,
    input  logic               advance,
    input  logic               start_new,
    input  logic [7:0]         data_byte,
    output bhmp_pkg::result_t  result
);
    import bhmp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic        have_held_reg, have_held_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  key_reg, key_next;
    logic        trailer_reg, trailer_next;

    // Effective state after an optional restart.
    phase_t      cur_phase;
    logic [7:0]  cur_held;
    logic        cur_have_held;
    logic [15:0] cur_left;
    logic [7:0]  cur_key;
    logic        cur_trailer;

    event_t      kind;
    logic [15:0] word;
    logic [15:0] joined;
    logic [15:0] left_dec;
    logic        last;

    // State registers, updated only when a byte moves to the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            held_reg      <= 8'd0;
            have_held_reg <= 1'b0;
            left_reg      <= 16'd0;
            key_reg       <= 8'd1;
            trailer_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            have_held_reg <= have_held_next;
            left_reg      <= left_next;
            key_reg       <= key_next;
            trailer_reg   <= trailer_next;
        end
    end

    // A start-new byte sees reset state, but with cfg.unknown_code as key.
    always_comb
    begin
        if (start_new)
        begin
            cur_phase     = PH_START;
            cur_held      = 8'd0;
            cur_have_held = 1'b0;
            cur_left      = 16'd0;
            cur_key       = cfg.unknown_code;
            cur_trailer   = 1'b0;
        end
        else
        begin
            cur_phase     = phase_reg;
            cur_held      = held_reg;
            cur_have_held = have_held_reg;
            cur_left      = left_reg;
            cur_key       = key_reg;
            cur_trailer   = trailer_reg;
        end
    end

    assign joined   = {cur_held, data_byte};
    assign left_dec = cur_left - 16'd1;

    // Per-byte parse step.
    always_comb
    begin
        phase_next     = cur_phase;
        held_next      = cur_held;
        have_held_next = cur_have_held;
        left_next      = cur_left;
        key_next       = cur_key;
        trailer_next   = cur_trailer;
        kind           = EV_UNCONSUMED;
        word           = 16'd0;
        last           = 1'b0;

        unique case (cur_phase)
            PH_START:
            begin
                if (cfg.is_request)
                begin
                    kind       = EV_VERB;
                    phase_next = PH_URL;
                end
                else
                begin
                    kind           = EV_HELD;
                    held_next      = data_byte;
                    have_held_next = 1'b1;
                    phase_next     = PH_STATUS;
                end
            end
            PH_URL:
            begin
                if (data_byte != 8'd0)
                    kind = EV_URL;
                else
                begin
                    kind       = EV_URL_END;
                    phase_next = PH_HSTART;
                end
            end
            PH_STATUS, PH_ESTART:
            begin
                if (!cur_have_held)
                begin
                    kind           = EV_HELD;
                    held_next      = data_byte;
                    have_held_next = 1'b1;
                end
                else
                begin
                    word           = joined;
                    have_held_next = 1'b0;
                    if (cur_phase == PH_STATUS)
                    begin
                        kind       = EV_STATUS;
                        phase_next = PH_HSTART;
                    end
                    else if (joined != 16'd0)
                    begin
                        kind       = EV_CHUNK_SIZE;
                        left_next  = joined;
                        phase_next = PH_ENTITY;
                    end
                    else
                    begin
                        kind       = EV_ENTITY_END;
                        left_next  = 16'd0;
                        phase_next = PH_HSTART;
                    end
                end
            end
            PH_HSTART:
            begin
                key_next = data_byte;
                word     = {8'd0, data_byte};
                // The end meaning wins when both codes are equal.
                if (data_byte == cfg.end_code)
                begin
                    if (!cur_trailer)
                    begin
                        kind           = EV_HDR_END;
                        trailer_next   = 1'b1;
                        have_held_next = 1'b0;
                        phase_next     = PH_ESTART;
                    end
                    else
                    begin
                        kind       = EV_DONE;
                        phase_next = PH_DONE;
                    end
                end
                else if (data_byte == cfg.unknown_code)
                begin
                    kind       = EV_UNKNOWN_KEY;
                    phase_next = PH_KEY;
                end
                else
                begin
                    kind       = EV_KNOWN_KEY;
                    phase_next = PH_VALUE;
                end
            end
            PH_KEY:
            begin
                word = {8'd0, cur_key};
                if (data_byte != 8'd0)
                    kind = EV_KEY_BYTE;
                else
                begin
                    kind       = EV_KEY_END;
                    phase_next = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                word = {8'd0, cur_key};
                if (data_byte != 8'd0)
                    kind = EV_VAL_BYTE;
                else
                begin
                    kind       = EV_VAL_END;
                    phase_next = PH_HSTART;
                end
            end
            PH_ENTITY:
            begin
                kind      = EV_ENTITY_BYTE;
                left_next = left_dec;
                if (left_dec == 16'd0)
                begin
                    last           = 1'b1;
                    have_held_next = 1'b0;
                    phase_next     = PH_ESTART;
                end
            end
            default:
            begin
                // Finished message and unused phase codes consume nothing.
                kind = EV_UNCONSUMED;
            end
        endcase
    end

    assign result.kind          = kind;
    assign result.byte_value    = data_byte;
    assign result.word_value    = word;
    assign result.in_trailer    = trailer_next;
    assign result.last_of_chunk = last;

endmodule

@@ rtl/binary_http_message_parser_core.sv @@
// ---------------------------------------------------------------------------
// binary_http_message_parser_core
// Tags each byte of a binary HTTP message with a parse event.
// ---------------------------------------------------------------------------
// Path: an accepted byte is held in the input register and then in the
// result register. Throughput: one byte per cycle unless out_ready stalls
// the result register, as the parse step between the two is combinational.
// Reset: rst_n clears both stages, the parse state and the configuration
// registers at once; no word is presented until a new byte is accepted.
module binary_http_message_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_new,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [4:0]  event_kind,
    output logic [7:0]  byte_value,
    output logic [15:0] word_value,
    output logic        in_trailer,
    output logic        last_of_chunk
);
    import bhmp_pkg::*;

    cfg_t        cfg;
    result_t     result;

    logic        in_valid_reg;
    logic        start_new_reg;
    logic [7:0]  data_byte_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        advance;

    // A byte moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    bhmp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            start_new_reg <= start_new;
            data_byte_reg <= data_byte;
        end
    end

    bhmp_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .advance   (advance),
        .start_new (start_new_reg),
        .data_byte (data_byte_reg),
        .result    (result)
    );

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_reg.kind;
    assign byte_value    = out_reg.byte_value;
    assign word_value    = out_reg.word_value;
    assign in_trailer    = out_reg.in_trailer;
    assign last_of_chunk = out_reg.last_of_chunk;

endmodule

@@ rtl/bhmp_checker.sv @@
// ---------------------------------------------------------------------------
// bhmp_checker
// Port-level checks on the parser core's result stream.
// ---------------------------------------------------------------------------
module bhmp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  event_kind,
    input logic [15:0] word_value,
    input logic        in_trailer,
    input logic        last_of_chunk
);
    import bhmp_pkg::*;

    // A stalled result holds its event.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind))
        else $error("result changed while stalled");

    // The end of a chunk is only ever marked on an entity byte.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_chunk |-> event_kind == 5'(EV_ENTITY_BYTE))
        else $error("last_of_chunk on a non-entity event");

    // The header end already reports the trailer section.
    a_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == 5'(EV_HDR_END) |-> in_trailer)
        else $error("header end without in_trailer");

    // Events that carry no word report zero.
    a_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == 5'(EV_HELD) || event_kind == 5'(EV_VERB)
            || event_kind == 5'(EV_URL) || event_kind == 5'(EV_URL_END)
            || event_kind == 5'(EV_ENTITY_BYTE) || event_kind == 5'(EV_UNCONSUMED))
        |-> word_value == 16'd0)
        else $error("nonzero word on an event without a word");

endmodule

bind binary_http_message_parser_core bhmp_checker u_bhmp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .word_value    (word_value),
    .in_trailer    (in_trailer),
    .last_of_chunk (last_of_chunk)
);
